@@ rtl/i2a_pkg.sv @@
`timescale 1ns / 1ps
// Package for the integer to ASCII formatter.
// Holds the mode codes, the character constants and the digit-to-character function.
package i2a_pkg;

	localparam int VALUE_BITS_DEF = 64;

	localparam logic [1:0] MODE_UNSIGNED = 2'd0;
	localparam logic [1:0] MODE_SIGNED   = 2'd1;
	localparam logic [1:0] MODE_POINTER  = 2'd2;

	localparam logic [7:0] CHAR_ZERO    = 8'd48;
	localparam logic [7:0] CHAR_X       = 8'h78;
	localparam logic [7:0] CHAR_MINUS   = 8'h2d;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base;
		begin
			base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
			if (d < 4'd10) begin
				digit_char = CHAR_ZERO + {4'd0, d};
			end else begin
				digit_char = base + {4'd0, d} - 8'd10;
			end
		end
	endfunction

endpackage

@@ rtl/integer_to_ascii_formatter_unit.sv @@
`timescale 1ns / 1ps
// Top level of the integer to ASCII formatter: sequencer, shift-add unit and output word.
// Depends on i2a_pkg for mode codes, characters and the digit-to-character function.
//
// Usage: one word on the slave side carries a number (s_tdata) and its format flags
// (s_tuser); the master side returns its ASCII characters, most significant first,
// one per word, with m_tlast on the final character. Pointer mode sends "0x" first,
// and signed decimal sends '-' before the magnitude of a negative value.
// The block takes one number at a time; s_tready is high only while it is idle.
// Decimal conversion runs a shift-and-add-three pass, one operand bit per cycle;
// hexadecimal needs no conversion. A leading-zero strip then shifts out one digit
// per cycle (at most the digit count less one), and the characters leave at one
// per cycle while the receiver accepts them.
// A stalled receiver holds the output word, and the sequencer waits.
// Reset empties the output word and returns the sequencer to idle; nothing else
// is kept between numbers.
module integer_to_ascii_formatter_unit #(
	parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // value [63:0]
	input  logic [3:0]  s_tuser,  // base_hex [0], upper_case [1], mode [3:2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // char_out [7:0]
	output logic        m_tlast
);

	localparam int NDIG = (VALUE_BITS * 30103 + 99999) / 100000;
	localparam int DW   = NDIG * 4;
	localparam int RW   = $clog2(NDIG + 1);
	localparam int CW   = $clog2(VALUE_BITS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SKIP = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]            state_q;
	logic [VALUE_BITS-1:0] sh_q;
	logic [DW-1:0]         dig_q;
	logic [RW-1:0]         rem_q;
	logic [CW-1:0]         bit_cnt_q;
	logic [15:0]           pre_q;
	logic [1:0]            pre_cnt_q;
	logic                  hex_q;
	logic                  upper_q;
	logic                  out_valid_q;
	logic [7:0]            out_char_q;
	logic                  out_last_q;

	logic [VALUE_BITS-1:0] v_in;
	logic [VALUE_BITS-1:0] mag;
	logic                  hex_in;
	logic                  neg_in;
	logic [1:0]            mode_in;
	logic [DW-1:0]         dig_adj;
	logic [3:0]            top_dig;
	logic                  out_free;

	assign v_in    = s_tdata[VALUE_BITS-1:0];
	assign mode_in = s_tuser[3:2];
	assign hex_in  = s_tuser[0] || (mode_in == i2a_pkg::MODE_POINTER);
	assign neg_in  = (mode_in == i2a_pkg::MODE_SIGNED) && !hex_in && v_in[VALUE_BITS-1];
	assign mag     = neg_in ? (~v_in + 1'b1) : v_in;
	assign top_dig = dig_q[DW-1 -: 4];
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			dig_adj[i*4 +: 4] = (dig_q[i*4 +: 4] >= 4'd5) ? dig_q[i*4 +: 4] + 4'd3
				: dig_q[i*4 +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= hex_in ? ST_SKIP : ST_CONV;
					end
				end
				ST_CONV: begin
					if (bit_cnt_q == CW'(1)) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (top_dig != 4'd0 || rem_q == RW'(1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free && pre_cnt_q == 2'd0 && rem_q == RW'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				sh_q      <= mag;
				dig_q     <= hex_in ? DW'(mag) : '0;
				rem_q     <= RW'(NDIG);
				bit_cnt_q <= CW'(VALUE_BITS);
				hex_q     <= hex_in;
				upper_q   <= s_tuser[1];
				if (mode_in == i2a_pkg::MODE_POINTER) begin
					pre_q     <= {i2a_pkg::CHAR_ZERO, i2a_pkg::CHAR_X};
					pre_cnt_q <= 2'd2;
				end else if (neg_in) begin
					pre_q     <= {i2a_pkg::CHAR_MINUS, 8'd0};
					pre_cnt_q <= 2'd1;
				end else begin
					pre_q     <= '0;
					pre_cnt_q <= 2'd0;
				end
			end
			ST_CONV: begin
				dig_q     <= {dig_adj[DW-2:0], sh_q[VALUE_BITS-1]};
				sh_q      <= {sh_q[VALUE_BITS-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q - 1'b1;
			end
			ST_SKIP: begin
				if (top_dig == 4'd0 && rem_q != RW'(1)) begin
					dig_q <= {dig_q[DW-5:0], 4'd0};
					rem_q <= rem_q - 1'b1;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					if (pre_cnt_q != 2'd0) begin
						out_char_q <= pre_q[15:8];
						out_last_q <= 1'b0;
						pre_q      <= {pre_q[7:0], 8'd0};
						pre_cnt_q  <= pre_cnt_q - 1'b1;
					end else begin
						out_char_q <= i2a_pkg::digit_char(top_dig, upper_q);
						out_last_q <= (rem_q == RW'(1));
						dig_q      <= {dig_q[DW-5:0], 4'd0};
						rem_q      <= rem_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tlast  = out_last_q;

	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SKIP || state_q == ST_EMIT) |-> rem_q != '0)
		else $error("Digit count ran out before the last character.");

	a_decimal_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !hex_q) |-> top_dig <= 4'd9)
		else $error("Decimal conversion left a digit above nine.");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_CONV || state_q == ST_SKIP))
		else $error("Accepted number did not start conversion.");

	a_prefix_first: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_free && pre_cnt_q != 2'd0) |=> !m_tlast)
		else $error("Prefix character marked as last.");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Testbench for integer_to_ascii_formatter_unit: directed and random numbers, with
// idling on both stream sides, and every character checked against a predictor.
// Depends on i2a_pkg and the formatter RTL only.
module tb;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_PER_PHASE = 75;
	localparam int DRAIN_CYCLES = 120;

	typedef struct {
		logic [63:0] value;
		logic        base_hex;
		logic        upper_case;
		logic [1:0]  mode;
	} number_t;

	typedef struct {
		logic [7:0] char_out;
		logic       last;
	} char_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [3:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	number_t    pending_numbers[$];
	char_word_t expected_chars[$];
	number_t    number_on_bus;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         mismatches = 0;
	int         cycle_count = 0;

	integer_to_ascii_formatter_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void format_number(input number_t n);
		logic [63:0] mag;
		logic [63:0] radix;
		logic        is_hex;
		logic [7:0]  letter_a;
		logic [3:0]  digs[20];
		int          nd;
		char_word_t  w;
		begin
			mag = n.value;
			is_hex = n.base_hex || (n.mode == i2a_pkg::MODE_POINTER);
			radix = is_hex ? 64'd16 : 64'd10;
			letter_a = n.upper_case ? i2a_pkg::CHAR_UPPER_A : i2a_pkg::CHAR_LOWER_A;
			nd = 0;
			w.last = 1'b0;
			if (n.mode == i2a_pkg::MODE_POINTER) begin
				w.char_out = i2a_pkg::CHAR_ZERO;
				expected_chars.push_back(w);
				w.char_out = i2a_pkg::CHAR_X;
				expected_chars.push_back(w);
			end
			if (n.mode == i2a_pkg::MODE_SIGNED && !is_hex && mag[63]) begin
				w.char_out = i2a_pkg::CHAR_MINUS;
				expected_chars.push_back(w);
				mag = ~mag + 64'd1;
			end
			do begin
				digs[nd] = 4'(mag % radix);
				nd++;
				mag = mag / radix;
			end while (mag != 64'd0 && nd < 20);
			for (int k = nd - 1; k >= 0; k--) begin
				if (digs[k] < 4'd10) begin
					w.char_out = i2a_pkg::CHAR_ZERO + 8'(digs[k]);
				end else begin
					w.char_out = letter_a + 8'(digs[k]) - 8'd10;
				end
				w.last = (k == 0);
				expected_chars.push_back(w);
			end
		end
	endfunction

	task automatic queue_number(input logic [63:0] value, input logic base_hex,
			input logic upper_case, input logic [1:0] mode);
		number_t n;
		begin
			n.value = value;
			n.base_hex = base_hex;
			n.upper_case = upper_case;
			n.mode = mode;
			pending_numbers.push_back(n);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				format_number(number_on_bus);
			end
			if (!s_tvalid || s_tready) begin
				if (pending_numbers.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					number_on_bus = pending_numbers.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= number_on_bus.value;
					s_tuser <= {number_on_bus.mode, number_on_bus.upper_case,
						number_on_bus.base_hex};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		char_word_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_chars.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Unexpected word: char 0x%02h last %0b", m_tdata, m_tlast);
					end
				end else begin
					want = expected_chars.pop_front();
					if (m_tdata !== want.char_out || m_tlast !== want.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Mismatch: expected char 0x%02h last %0b, got char 0x%02h last %0b",
								want.char_out, want.last, m_tdata, m_tlast);
						end
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL integer_to_ascii_formatter_unit");
			$finish;
		end
	end

	initial begin
		int          idle_tab[4];
		int          stall_tab[4];
		logic [63:0] v;
		logic [1:0]  m;
		idle_tab = '{0, 54, 0, 6};
		stall_tab = '{0, 0, 54, 6};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		for (int ph = 0; ph < 4; ph++) begin
			@(negedge clk);
			send_idle_pct = idle_tab[ph];
			recv_stall_pct = stall_tab[ph];
			if (ph == 0) begin
				queue_number(64'd0, 1'b0, 1'b0, i2a_pkg::MODE_UNSIGNED);
				queue_number(64'd0, 1'b1, 1'b0, i2a_pkg::MODE_UNSIGNED);
				queue_number(64'd0, 1'b0, 1'b0, i2a_pkg::MODE_SIGNED);
				queue_number(64'd0, 1'b1, 1'b1, i2a_pkg::MODE_POINTER);
				queue_number('1, 1'b0, 1'b0, i2a_pkg::MODE_UNSIGNED);
				queue_number('1, 1'b1, 1'b0, i2a_pkg::MODE_UNSIGNED);
				queue_number('1, 1'b1, 1'b1, i2a_pkg::MODE_UNSIGNED);
				queue_number('1, 1'b0, 1'b0, i2a_pkg::MODE_SIGNED);
				queue_number('1, 1'b1, 1'b1, i2a_pkg::MODE_SIGNED);
				queue_number('1, 1'b0, 1'b0, i2a_pkg::MODE_POINTER);
				queue_number(64'h8000_0000_0000_0000, 1'b0, 1'b0, i2a_pkg::MODE_SIGNED);
				queue_number(64'h8000_0000_0000_0000, 1'b1, 1'b0, i2a_pkg::MODE_SIGNED);
				queue_number(64'h7fff_ffff_ffff_ffff, 1'b0, 1'b1, i2a_pkg::MODE_SIGNED);
				queue_number(64'h0123_4567_89ab_cdef, 1'b0, 1'b1, i2a_pkg::MODE_POINTER);
				queue_number(64'hfedc_ba98_7654_3210, 1'b1, 1'b0, i2a_pkg::MODE_POINTER);
				queue_number(64'd9, 1'b0, 1'b0, i2a_pkg::MODE_UNSIGNED);
				queue_number(64'd10, 1'b0, 1'b0, i2a_pkg::MODE_UNSIGNED);
				queue_number(64'd15, 1'b1, 1'b1, i2a_pkg::MODE_UNSIGNED);
				queue_number(64'd16, 1'b1, 1'b0, i2a_pkg::MODE_UNSIGNED);
				queue_number(64'd9999999999999999999, 1'b0, 1'b0, i2a_pkg::MODE_UNSIGNED);
				queue_number(64'd10000000000000000000, 1'b0, 1'b0, i2a_pkg::MODE_UNSIGNED);
				queue_number(64'hdead_beef_cafe_f00d, 1'b0, 1'b1, MODE_SPARE);
				queue_number(64'hffff_ffff_ffff_ff85, 1'b0, 1'b0, MODE_SPARE);
			end
			repeat (RANDOM_PER_PHASE) begin
				v = {$urandom, $urandom};
				case ($urandom_range(3))
					0: v = v >> $urandom_range(63);
					1: v = 64'($urandom_range(1000));
					2: v = ~(64'($urandom_range(1000))) + 64'd1;
					default: ;
				endcase
				m = 2'($urandom_range(3));
				queue_number(v, 1'($urandom), 1'($urandom), m);
			end
			while (pending_numbers.size() != 0 || s_tvalid || expected_chars.size() != 0) begin
				@(negedge clk);
			end
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && expected_chars.size() == 0) begin
			$display("PASS integer_to_ascii_formatter_unit");
		end else begin
			$display("FAIL integer_to_ascii_formatter_unit");
		end
		$finish;
	end

endmodule
